### src/imlm_pkg.sv
`default_nettype none

package imlm_pkg;

    // table sizing
    localparam int NUM_ENTRIES = 64;
    localparam int NUM_CPUS    = 8;
    localparam int NUM_LISTS   = NUM_CPUS + 3;

    // internal widths derived from the sizing
    localparam int ENT_W  = $clog2(NUM_ENTRIES);
    localparam int LST_W  = $clog2(NUM_LISTS);
    localparam int CPU_W  = $clog2(NUM_CPUS + 1);
    localparam int STEP_W = $clog2(NUM_ENTRIES + 1);

    // fixed field widths of the transaction payloads
    localparam int OP_W      = 1;
    localparam int LIST_ID_W = 4;
    localparam int ENTRY_W   = 6;
    localparam int HEAD_W    = 6;
    localparam int OWNER_W   = 4;

    // operation codes
    localparam logic [OP_W-1:0] OP_APPEND = 1'b0;
    localparam logic [OP_W-1:0] OP_REMOVE = 1'b1;

    // input transaction
    typedef struct packed {
        logic [OP_W-1:0]      operation;
        logic [LIST_ID_W-1:0] list_id;
        logic [ENTRY_W-1:0]   entry_index;
    } t_in_item;

    // result transaction
    typedef struct packed {
        logic               status;
        logic               head_valid;
        logic [HEAD_W-1:0]  head_index;
        logic [OWNER_W-1:0] entry_owner;
    } t_out_item;

    // read address source for the link memory
    typedef enum logic [1:0] {
        NSEL_HEAD,
        NSEL_DATA,
        NSEL_ENT
    } t_nsel;

    // source of a new list head
    typedef enum logic {
        HW_ENT,
        HW_NEXT
    } t_hsel;

    // source of the walk pointer
    typedef enum logic {
        CUR_HEAD,
        CUR_DATA
    } t_csel;

    // controller to datapath commands
    typedef struct packed {
        logic  load;
        logic  set_fail;
        logic  rd_next;
        t_nsel nsel;
        logic  cur_ld;
        t_csel csel;
        logic  steps_clr;
        logic  steps_inc;
        logic  head_wr;
        t_hsel hsel;
        logic  nx_wr_ent;
        logic  nx_wr_data;
        logic  nx_clr;
        logic  cpu_wr;
        logic  rd_cpu;
        logic  res_load;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic lst_ok;
        logic ent_ok;
        logic is_rm;
        logic lst_cpu;
        logic head_v;
        logic head_is_ent;
        logic nx_link;
        logic nx_is_ent;
        logic steps_full;
        logic steps_last;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

### src/imlm_ram.sv
`default_nettype none

module imlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### src/imlm_ctrl.sv
`default_nettype none

module imlm_ctrl
    import imlm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_A_WALK = 4'd2;
    localparam logic [3:0] S_R_WALK = 4'd3;
    localparam logic [3:0] S_R_HEAD = 4'd4;
    localparam logic [3:0] S_R_LINK = 4'd5;
    localparam logic [3:0] S_CLR    = 4'd6;
    localparam logic [3:0] S_OWN    = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_ready = (r_state == S_IDLE);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (!i_stat.lst_ok || !i_stat.ent_ok) begin
                    o_cmd.set_fail = 1'b1;
                    n_state        = S_OWN;
                end else if (!i_stat.is_rm) begin
                    if (!i_stat.head_v) begin
                        o_cmd.head_wr = 1'b1;
                        o_cmd.hsel    = HW_ENT;
                        n_state       = S_CLR;
                    end else begin
                        o_cmd.cur_ld    = 1'b1;
                        o_cmd.csel      = CUR_HEAD;
                        o_cmd.steps_clr = 1'b1;
                        o_cmd.rd_next   = 1'b1;
                        o_cmd.nsel      = NSEL_HEAD;
                        n_state         = S_A_WALK;
                    end
                end else if (!i_stat.head_v) begin
                    o_cmd.set_fail = 1'b1;
                    n_state        = S_OWN;
                end else if (i_stat.head_is_ent) begin
                    o_cmd.rd_next = 1'b1;
                    o_cmd.nsel    = NSEL_ENT;
                    n_state       = S_R_HEAD;
                end else begin
                    o_cmd.cur_ld    = 1'b1;
                    o_cmd.csel      = CUR_HEAD;
                    o_cmd.steps_clr = 1'b1;
                    o_cmd.rd_next   = 1'b1;
                    o_cmd.nsel      = NSEL_HEAD;
                    n_state         = S_R_WALK;
                end
            end
            // walk to the tail, one link per cycle
            S_A_WALK: begin
                priority if (i_stat.nx_link && i_stat.steps_full) begin
                    o_cmd.set_fail = 1'b1;
                    n_state        = S_OWN;
                end else if (i_stat.nx_link) begin
                    o_cmd.cur_ld    = 1'b1;
                    o_cmd.csel      = CUR_DATA;
                    o_cmd.steps_inc = 1'b1;
                    o_cmd.rd_next   = 1'b1;
                    o_cmd.nsel      = NSEL_DATA;
                end else begin
                    o_cmd.nx_wr_ent = 1'b1;
                    n_state         = S_CLR;
                end
            end
            // search for the predecessor of the entry
            S_R_WALK: begin
                priority if (!i_stat.nx_link) begin
                    o_cmd.set_fail = 1'b1;
                    n_state        = S_OWN;
                end else if (i_stat.nx_is_ent) begin
                    o_cmd.rd_next = 1'b1;
                    o_cmd.nsel    = NSEL_ENT;
                    n_state       = S_R_LINK;
                end else if (i_stat.steps_last) begin
                    o_cmd.set_fail = 1'b1;
                    n_state        = S_OWN;
                end else begin
                    o_cmd.cur_ld    = 1'b1;
                    o_cmd.csel      = CUR_DATA;
                    o_cmd.steps_inc = 1'b1;
                    o_cmd.rd_next   = 1'b1;
                    o_cmd.nsel      = NSEL_DATA;
                end
            end
            S_R_HEAD: begin
                o_cmd.head_wr = 1'b1;
                o_cmd.hsel    = HW_NEXT;
                n_state       = S_CLR;
            end
            S_R_LINK: begin
                o_cmd.nx_wr_data = 1'b1;
                n_state          = S_CLR;
            end
            // terminate the entry and, when it is appended to a CPU list, record its owner
            S_CLR: begin
                o_cmd.nx_clr = 1'b1;
                o_cmd.cpu_wr = !i_stat.is_rm && i_stat.lst_cpu;
                n_state      = S_OWN;
            end
            S_OWN: begin
                o_cmd.rd_cpu = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/imlm_dp.sv
`default_nettype none

module imlm_dp
    import imlm_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_in_item  i_in_data,
    input  wire t_dp_cmd   i_cmd,
    output t_dp_stat       o_stat,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data
);

    t_in_item          r_item;
    logic              r_fail;
    logic [ENT_W-1:0]  r_cur;
    logic [STEP_W-1:0] r_steps;

    // list heads
    logic [NUM_LISTS-1:0] r_head_v;
    logic [ENT_W-1:0]     r_head [NUM_LISTS];

    // per-entry valid bits for the link and owner memories
    logic [NUM_ENTRIES-1:0] r_nv_bits;
    logic [NUM_ENTRIES-1:0] r_cv_bits;
    logic                   r_nv;
    logic                   r_cv;

    logic [ENT_W-1:0] nx_rdata;
    logic [CPU_W-1:0] cpu_rdata;
    logic [ENT_W-1:0] nx_raddr;
    logic             nx_we;
    logic [ENT_W-1:0] nx_wdata;

    logic [31:0]      ent32;
    logic [31:0]      lst32;
    logic [ENT_W-1:0] ent_idx;
    logic [LST_W-1:0] lst_idx;
    logic             ent_ok;
    logic             lst_ok;
    logic             head_v;
    logic [ENT_W-1:0] head;
    logic [31:0]      head32;
    logic [31:0]      owner32;

    t_out_item r_out;
    logic      r_out_v;

    // item fields resized to the table
    assign ent32   = 32'(r_item.entry_index);
    assign lst32   = 32'(r_item.list_id);
    assign ent_idx = ent32[ENT_W-1:0];
    assign lst_idx = lst32[LST_W-1:0];
    assign ent_ok  = ent32 < 32'(NUM_ENTRIES);
    assign lst_ok  = lst32 < 32'(NUM_LISTS);
    assign head_v  = lst_ok && r_head_v[lst_idx];
    assign head    = lst_ok ? r_head[lst_idx] : '0;

    // status to the controller
    always_comb begin
        o_stat.lst_ok      = lst_ok;
        o_stat.ent_ok      = ent_ok;
        o_stat.is_rm       = (r_item.operation == OP_REMOVE);
        o_stat.lst_cpu     = lst32 < 32'(NUM_CPUS);
        o_stat.head_v      = head_v;
        o_stat.head_is_ent = (head == ent_idx);
        o_stat.nx_link     = r_nv;
        o_stat.nx_is_ent   = (nx_rdata == ent_idx);
        o_stat.steps_full  = (r_steps == STEP_W'(NUM_ENTRIES));
        o_stat.steps_last  = (r_steps == STEP_W'(NUM_ENTRIES - 1));
        o_stat.out_free    = !r_out_v || !i_out_stall;
    end

    // item capture, walk pointer and step count
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_data;
        end
        if (i_cmd.cur_ld) begin
            r_cur <= (i_cmd.csel == CUR_HEAD) ? head : nx_rdata;
        end
        if (i_cmd.steps_clr) begin
            r_steps <= '0;
        end else if (i_cmd.steps_inc) begin
            r_steps <= r_steps + STEP_W'(1);
        end
    end

    // outcome flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail <= 1'b0;
        end else if (i_cmd.load) begin
            r_fail <= 1'b0;
        end else if (i_cmd.set_fail) begin
            r_fail <= 1'b1;
        end
    end

    // list head table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_v <= '0;
        end else if (i_cmd.head_wr) begin
            r_head_v[lst_idx] <= (i_cmd.hsel == HW_ENT) ? 1'b1 : r_nv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.head_wr) begin
            r_head[lst_idx] <= (i_cmd.hsel == HW_ENT) ? ent_idx : nx_rdata;
        end
    end

    // link memory addressing
    always_comb begin
        unique case (i_cmd.nsel)
            NSEL_HEAD: nx_raddr = head;
            NSEL_DATA: nx_raddr = nx_rdata;
            NSEL_ENT:  nx_raddr = ent_idx;
            default:   nx_raddr = ent_idx;
        endcase
    end

    assign nx_we    = i_cmd.nx_wr_ent || (i_cmd.nx_wr_data && r_nv);
    assign nx_wdata = i_cmd.nx_wr_ent ? ent_idx : nx_rdata;

    // link valid bits; a clear bit means end of list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nv_bits <= '0;
            r_nv      <= 1'b0;
        end else begin
            if (i_cmd.nx_wr_ent) begin
                r_nv_bits[r_cur] <= 1'b1;
            end else if (i_cmd.nx_wr_data) begin
                r_nv_bits[r_cur] <= r_nv;
            end else if (i_cmd.nx_clr) begin
                r_nv_bits[ent_idx] <= 1'b0;
            end
            if (i_cmd.rd_next) begin
                r_nv <= r_nv_bits[nx_raddr];
            end
        end
    end

    imlm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_ENTRIES)
    ) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (nx_we),
        .i_waddr (r_cur),
        .i_wdata (nx_wdata),
        .i_re    (i_cmd.rd_next),
        .i_raddr (nx_raddr),
        .o_rdata (nx_rdata)
    );

    // owner valid bits; a clear bit means no owner
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv_bits <= '0;
            r_cv      <= 1'b0;
        end else begin
            if (i_cmd.cpu_wr) begin
                r_cv_bits[ent_idx] <= 1'b1;
            end
            if (i_cmd.rd_cpu) begin
                r_cv <= r_cv_bits[ent_idx];
            end
        end
    end

    imlm_ram #(
        .WIDTH (CPU_W),
        .DEPTH (NUM_ENTRIES)
    ) u_cpu_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.cpu_wr),
        .i_waddr (ent_idx),
        .i_wdata (lst32[CPU_W-1:0]),
        .i_re    (i_cmd.rd_cpu),
        .i_raddr (ent_idx),
        .o_rdata (cpu_rdata)
    );

    // result fields
    assign head32  = head_v ? 32'(head) : 32'd0;
    assign owner32 = (ent_ok && r_cv) ? 32'(cpu_rdata) : 32'(NUM_CPUS);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_v <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_out.status      <= r_fail;
            r_out.head_valid  <= head_v;
            r_out.head_index  <= head32[HEAD_W-1:0];
            r_out.entry_owner <= owner32[OWNER_W-1:0];
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

### src/indexed_multi_list_manager_top.sv
`default_nettype none

// Linked-list manager for a fixed table of 64 entries shared by one run list per
// CPU plus sleeping, zombie and free lists. Each input transaction appends an
// entry at the tail of a list or removes it, and returns one result transaction
// with the outcome, the list's new head and the entry's owner CPU. One
// transaction is processed at a time. The walk along a list is bounded by the
// single read port of the link memory, which yields one link per cycle. A
// finished result waits in an output register, and the next input transaction
// is taken while it is still held.
module indexed_multi_list_manager_top
    import imlm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_item     o_out_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     ready;

    assign o_in_stall = !ready;

    // sequencer
    imlm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_ready    (ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // list tables, memories and result register
    imlm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

### src/imlm_checker.sv
`default_nettype none

module imlm_checker
    import imlm_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire t_in_item  i_in_data,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_data
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // one transaction in work at a time
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while busy");

    // an empty list reports head zero
    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.head_valid |-> o_out_data.head_index == '0)
        else $error("head index set for empty list");

    // owner is a cpu or none
    a_owner_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_out_data.entry_owner) <= 32'(NUM_CPUS))
        else $error("owner out of range");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("result changed while stalled");

endmodule

bind indexed_multi_list_manager_top imlm_checker u_imlm_checker (.*);

`default_nettype wire
